// ===== design/dr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dr_pkg: shared types and constants for the double remainder unit
// Holds the field layout of binary64 and the sequencer state encoding.
// ----------------------------------------------------------------------------
package dr_pkg;

    localparam int unsigned SigW = 53;
    localparam int unsigned ExpW = 11;
    localparam int unsigned BexpW = 13;

    localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
    localparam logic [ExpW-1:0] ExpAll1 = 11'h7FF;

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_NORM  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_RNORM = 6'b001000,
        ST_DENRM = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

// ===== design/double_remainder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_remainder: exact binary64 fmod on raw bit patterns
// Special cases go straight to the output state; otherwise the sequencer
// normalizes both operands, runs one restoring shift-subtract step per unit of
// exponent difference, then normalizes and denormalizes the result. One beat in
// flight: a new input is taken only in idle. Reset clears the sequencer and valid.
// ----------------------------------------------------------------------------
module double_remainder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] dividend_bits,
    input  logic [63:0] divisor_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] remainder_bits
);

    dr_pkg::state_t state_reg, state_next;

    // Working registers.
    logic [54:0]                      m_reg, m_next;
    logic [dr_pkg::SigW-1:0]          my_reg, my_next;
    logic signed [dr_pkg::BexpW-1:0]  bx_reg, bx_next;
    logic signed [dr_pkg::BexpW-1:0]  by_reg, by_next;
    logic                             sign_reg, sign_next;
    logic [63:0]                      res_reg, res_next;

    // Input decode.
    logic [62:0] ax, ay;
    logic [10:0] ex, ey;
    logic        fy_nz, special_nan, pass_x, is_eq;
    // Shared subtract unit.
    logic [55:0] diff;
    logic        ge;

    assign ax = dividend_bits[62:0];
    assign ay = divisor_bits[62:0];
    assign ex = ax[62:52];
    assign ey = ay[62:52];
    assign fy_nz = |ay[51:0];
    assign special_nan = (ex == dr_pkg::ExpAll1) || ((ey == dr_pkg::ExpAll1) && fy_nz)
                         || (ay == 63'd0);
    assign pass_x = ((ey == dr_pkg::ExpAll1) && !fy_nz) || (ax == 63'd0) || (ax < ay);
    assign is_eq = (ax == ay);

    assign diff = {1'b0, m_reg} - {3'b000, my_reg};
    assign ge = !diff[55];

    assign in_stall = (state_reg != dr_pkg::ST_IDLE);
    assign out_valid = (state_reg == dr_pkg::ST_OUT);
    assign remainder_bits = res_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg;
        my_next = my_reg;
        bx_next = bx_reg;
        by_next = by_reg;
        sign_next = sign_reg;
        res_next = res_reg;
        case (state_reg)
            dr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sign_next = dividend_bits[63];
                    m_next = {2'b00, (ex != 11'd0), ax[51:0]};
                    my_next = {(ey != 11'd0), ay[51:0]};
                    bx_next = (ex == 11'd0) ? 13'sd1 : $signed({2'b00, ex});
                    by_next = (ey == 11'd0) ? 13'sd1 : $signed({2'b00, ey});
                    if (special_nan)
                    begin
                        res_next = dr_pkg::QnanBits;
                        state_next = dr_pkg::ST_OUT;
                    end
                    else if (pass_x)
                    begin
                        res_next = dividend_bits;
                        state_next = dr_pkg::ST_OUT;
                    end
                    else if (is_eq)
                    begin
                        res_next = {dividend_bits[63], 63'd0};
                        state_next = dr_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = dr_pkg::ST_NORM;
                    end
                end
            end
            dr_pkg::ST_NORM:
            begin
                // One bit of normalization per cycle, on the dividend first, then the divisor.
                if (!m_reg[52])
                begin
                    m_next = {m_reg[53:0], 1'b0};
                    bx_next = bx_reg - 13'sd1;
                end
                else if (!my_reg[52])
                begin
                    my_next = {my_reg[51:0], 1'b0};
                    by_next = by_reg - 13'sd1;
                end
                else
                begin
                    state_next = dr_pkg::ST_DIV;
                end
            end
            dr_pkg::ST_DIV:
            begin
                // Restoring step; bx counts down to by.
                if (bx_reg > by_reg)
                begin
                    m_next = ge ? {diff[53:0], 1'b0} : {m_reg[53:0], 1'b0};
                    bx_next = bx_reg - 13'sd1;
                end
                else
                begin
                    m_next = ge ? diff[54:0] : m_reg;
                    state_next = dr_pkg::ST_RNORM;
                end
            end
            dr_pkg::ST_RNORM:
            begin
                if (m_reg == 55'd0)
                begin
                    res_next = {sign_reg, 63'd0};
                    state_next = dr_pkg::ST_OUT;
                end
                else if (!m_reg[52])
                begin
                    m_next = {m_reg[53:0], 1'b0};
                    by_next = by_reg - 13'sd1;
                end
                else if (by_reg >= 13'sd1)
                begin
                    res_next = {sign_reg, by_reg[10:0], m_reg[51:0]};
                    state_next = dr_pkg::ST_OUT;
                end
                else
                begin
                    state_next = dr_pkg::ST_DENRM;
                end
            end
            dr_pkg::ST_DENRM:
            begin
                // Shift right until the exponent reaches one; drops only zeros.
                if (by_reg < 13'sd1)
                begin
                    m_next = {1'b0, m_reg[54:1]};
                    by_next = by_reg + 13'sd1;
                end
                else
                begin
                    res_next = {sign_reg, 11'd0, m_reg[51:0]};
                    state_next = dr_pkg::ST_OUT;
                end
            end
            dr_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = dr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        my_reg <= my_next;
        bx_reg <= bx_next;
        by_reg <= by_next;
        sign_reg <= sign_next;
        res_reg <= res_next;
    end

    // The partial remainder stays below twice the divisor during division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dr_pkg::ST_DIV) |-> (m_reg < {my_reg, 1'b0}))
        else $error("partial remainder out of range");

    // A result beat holds while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(remainder_bits)))
        else $error("result changed under stall");

    // Input is never taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while busy");

endmodule
